FILE: hw/rtl/bidq_pkg.sv
// Package for the bounded indexed deque: request codes, payload structs,
// controller/datapath command and status types. No dependencies.
package bidq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_INSERT     = 3'd4;
    localparam logic [2:0] REQ_REMOVE     = 3'd5;
    localparam logic [2:0] REQ_READ       = 3'd6;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [6:0]         position;
    } req_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] read_value;
        logic [6:0]         element_total;
    } rsp_t;

    typedef struct packed {
        logic start;       // latch request, evaluate
        logic shift_rd;    // read store at shift source
        logic shift_wr;    // write shifted word, advance cursor
        logic final_wr;    // do end write / pointer update
        logic read_rd;     // read at position
        logic finish;      // build response
    } cmd_t;

    typedef struct packed {
        logic fail;
        logic need_shift;  // insert/remove with elements to move
        logic shift_last;  // current shift step is the last one
        logic is_read;
    } sts_t;

endpackage

FILE: hw/rtl/bidq_datapath.sv
// Datapath: element store, front pointer, count, shift cursor and response.
// Depends on bidq_pkg.
module bidq_datapath import bidq_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [2:0]    type_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [CW-1:0] pos_reg;
    logic          fail_reg, fail_next;
    logic          rd_ok_reg;
    rsp_t          rsp_reg, rsp_next;

    logic          pos_big;
    logic [CW-1:0] pos_w;
    logic          full, empty;
    logic [AW-1:0] rd_addr, wr_addr, fin_addr;
    logic [CW-1:0] src_idx, fin_idx;

    // f < CAPACITY and i <= CAPACITY, so one conditional subtract wraps the sum
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] i);
        logic [AW+CW:0] s;
        s = {{(CW+1){1'b0}}, f} + {{(AW+1){1'b0}}, i};
        if (s >= (AW+CW+1)'(CAPACITY)) s = s - (AW+CW+1)'(CAPACITY);
        return s[AW-1:0];
    endfunction

    always_comb begin
        pos_big = 1'b0;
        for (int b = CW; b < 7; b++) if (req.position[b]) pos_big = 1'b1;
        pos_w = CW'(req.position);
    end

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb begin
        fail_next = fail_reg;
        if (cmd.start) begin
            case (req.req_type)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: fail_next = full;
                REQ_POP_FRONT, REQ_POP_BACK:   fail_next = empty;
                REQ_INSERT: fail_next = full || pos_big || (pos_w > count_reg);
                REQ_REMOVE, REQ_READ: fail_next = pos_big || (pos_w >= count_reg);
                default: fail_next = 1'b1;
            endcase
        end
    end

    // shift source index: insert moves cur-1 -> cur, remove moves cur+1 -> cur
    assign src_idx = (type_reg == REQ_INSERT) ? cur_reg - 1'b1 : cur_reg + 1'b1;
    assign rd_addr = cmd.read_rd ? slot(front_reg, pos_reg) : slot(front_reg, src_idx);
    assign wr_addr = slot(front_reg, cur_reg);

    assign sts.fail       = fail_reg;
    assign sts.is_read    = (type_reg == REQ_READ);
    assign sts.need_shift = (type_reg == REQ_INSERT) ? (count_reg > pos_reg)
                          : (type_reg == REQ_REMOVE) ? (count_reg - 1'b1 > pos_reg) : 1'b0;
    assign sts.shift_last = (type_reg == REQ_INSERT) ? (cur_reg - 1'b1 == pos_reg)
                          : (cur_reg + CW'(2) == count_reg);

    assign fin_idx = (type_reg == REQ_PUSH_BACK) ? count_reg : pos_reg;
    assign fin_addr = (type_reg == REQ_PUSH_FRONT) ? front_next : slot(front_reg, fin_idx);

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.final_wr && !fail_reg) begin
            case (type_reg)
                REQ_PUSH_FRONT: begin
                    front_next = (front_reg == '0) ? AW'(CAPACITY - 1) : front_reg - 1'b1;
                    count_next = count_reg + 1'b1;
                end
                REQ_PUSH_BACK, REQ_INSERT: count_next = count_reg + 1'b1;
                REQ_POP_FRONT: begin
                    front_next = (front_reg == AW'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
                REQ_POP_BACK, REQ_REMOVE: count_next = count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_next = cur_reg;
        if (cmd.start)
            cur_next = (req.req_type == REQ_INSERT) ? count_reg : pos_w;
        else if (cmd.shift_wr)
            cur_next = (type_reg == REQ_INSERT) ? cur_reg - 1'b1 : cur_reg + 1'b1;
    end

    always_comb begin
        rsp_next = rsp_reg;
        if (cmd.finish) begin
            rsp_next.status        = fail_reg;
            rsp_next.read_value    = (rd_ok_reg && !fail_reg) ? 32'(signed'(rdata_reg)) : '0;
            rsp_next.element_total = 7'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            fail_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
            if (cmd.start) rd_ok_reg <= 1'b0;
            else if (cmd.read_rd) rd_ok_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        rsp_reg <= rsp_next;
        if (cmd.start) begin
            type_reg <= req.req_type;
            data_reg <= DATA_WIDTH'(req.value);
            pos_reg  <= pos_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_rd || cmd.read_rd) rdata_reg <= mem[rd_addr];
        if (cmd.shift_wr) mem[wr_addr] <= rdata_reg;
        else if (cmd.final_wr && !fail_reg && (type_reg == REQ_PUSH_FRONT ||
                 type_reg == REQ_PUSH_BACK || type_reg == REQ_INSERT))
            mem[fin_addr] <= data_reg;
    end

    assign rsp = rsp_reg;
endmodule

FILE: hw/rtl/bidq_ctrl.sv
// Controller FSM: sequences evaluate, shift, final write, read and response.
// Depends on bidq_pkg.
module bidq_ctrl import bidq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_SRD   = 3'd2;
    localparam logic [2:0] ST_SWR   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                cmd.start  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (sts.fail)            state_next = ST_FIN;
                else if (sts.is_read)    state_next = ST_READ;
                else if (sts.need_shift) state_next = ST_SRD;
                else                     state_next = ST_FIN;
            end
            ST_SRD: begin
                cmd.shift_rd = 1'b1;
                state_next   = ST_SWR;
            end
            ST_SWR: begin
                cmd.shift_wr = 1'b1;
                state_next   = sts.shift_last ? ST_FIN : ST_SRD;
            end
            ST_READ: begin
                cmd.read_rd = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                cmd.final_wr = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                cmd.finish = 1'b1;
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule

FILE: hw/rtl/bounded_indexed_deque_core.sv
// Channel   Ports                             Payload
// input     s_valid / s_ready / s_req         req_t
// result    m_valid / m_ready / m_rsp         rsp_t
// End requests and failures pass through evaluate, final write and response; reads
// add a store read, and insert and remove add a read and a write per moved element.
// One request in flight; a new request is taken once the result is taken.
// aresetn (sync, active low) clears pointer and count; store contents stay.
// Top level: instantiates bidq_ctrl and bidq_datapath, depends on bidq_pkg.
module bounded_indexed_deque_core import bidq_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);
    cmd_t cmd;
    sts_t sts;

    bidq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    bidq_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .req(s_req), .cmd(cmd), .sts(sts), .rsp(m_rsp)
    );
endmodule

FILE: test/tb.sv
// Testbench for bounded_indexed_deque_core: random and directed deque requests
// checked against an in-bench list model. Depends on bidq_pkg and the RTL.
module tb import bidq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;
    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    bounded_indexed_deque_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic signed [31:0] list_model[$];
    int mismatches = 0;
    int send_idle = 18;
    int recv_idle = 56;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    function automatic rsp_t deque_predict(req_t r);
        rsp_t o;
        int n;
        o = '0;
        n = list_model.size();
        case (r.req_type)
            REQ_PUSH_FRONT: if (n >= CAP) o.status = 1'b1;
                            else list_model.push_front(r.value);
            REQ_PUSH_BACK:  if (n >= CAP) o.status = 1'b1;
                            else list_model.push_back(r.value);
            REQ_POP_FRONT:  if (n == 0) o.status = 1'b1;
                            else void'(list_model.pop_front());
            REQ_POP_BACK:   if (n == 0) o.status = 1'b1;
                            else void'(list_model.pop_back());
            REQ_INSERT:     if (n >= CAP || r.position > n) o.status = 1'b1;
                            else list_model.insert(r.position, r.value);
            REQ_REMOVE:     if (r.position >= n) o.status = 1'b1;
                            else list_model.delete(r.position);
            REQ_READ:       if (r.position >= n) o.status = 1'b1;
                            else o.read_value = list_model[r.position];
            default:        o.status = 1'b1;
        endcase
        o.element_total = 7'(list_model.size());
        return o;
    endfunction

    function automatic req_t make_req(logic [2:0] t, int v, int p);
        req_t r;
        r.req_type = t;
        r.value = 32'(v);
        r.position = 7'(p);
        return r;
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready) begin
                void'(pending_reqs.pop_front());
                expected_rsps.push_back(deque_predict(s_req));
            end
            if (s_valid && s_ready && pending_reqs.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                s_valid <= 1'b1;
                s_req <= pending_reqs[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %p", m_rsp);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (m_rsp.status !== exp_rsp.status
                        || m_rsp.read_value !== exp_rsp.read_value
                        || m_rsp.element_total !== exp_rsp.element_total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", exp_rsp, m_rsp);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[bounded_indexed_deque_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_rsps.size() == 0);
    endtask

    // Build a batch of random requests; the predictor is not touched here, so
    // queue depth is approximated by a shadow count.
    task automatic queue_random(int count);
        int shadow;
        int k;
        logic [2:0] t;
        shadow = list_model.size();
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 19) == 0) t = 3'($urandom_range(0, 7));
            else if (shadow < 8) t = ($urandom_range(0, 2) == 0) ? REQ_INSERT
                                      : 3'($urandom_range(0, 1));
            else t = 3'($urandom_range(0, 6));
            case (t)
                REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: if (shadow < CAP) shadow++;
                REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE: if (shadow > 0) shadow--;
                default: ;
            endcase
            pending_reqs.push_back(make_req(t, $urandom,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, shadow)));
        end
    endtask

    initial begin
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: empty corner cases, then small-deque and bad-request cases
        pending_reqs.push_back(make_req(REQ_POP_FRONT, 0, 0));
        pending_reqs.push_back(make_req(REQ_POP_BACK, 0, 0));
        pending_reqs.push_back(make_req(REQ_READ, 0, 0));
        pending_reqs.push_back(make_req(REQ_REMOVE, 0, 0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh7fffffff, 1));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh7fffffff, 0));
        pending_reqs.push_back(make_req(REQ_REMOVE, 0, 0));
        pending_reqs.push_back(make_req(REQ_PUSH_FRONT, 32'sh80000000, 0));
        pending_reqs.push_back(make_req(REQ_PUSH_BACK, -1, 0));
        pending_reqs.push_back(make_req(REQ_INSERT, 32'sh5a5a5a5a, 1));
        pending_reqs.push_back(make_req(REQ_READ, 0, 0));
        pending_reqs.push_back(make_req(REQ_READ, 0, 1));
        pending_reqs.push_back(make_req(REQ_READ, 0, 2));
        pending_reqs.push_back(make_req(REQ_READ, 0, 127));
        pending_reqs.push_back(make_req(3'd7, -1, 127));
        pending_reqs.push_back(make_req(REQ_REMOVE, 0, 1));
        pending_reqs.push_back(make_req(REQ_POP_BACK, 0, 0));
        pending_reqs.push_back(make_req(REQ_POP_FRONT, 0, 0));
        drain();
        // receiver holds off first; then fill past capacity and probe the full deque
        hold_cycles = 600;
        for (k = 0; k < CAP + 2; k++)
            pending_reqs.push_back(make_req(REQ_PUSH_BACK, $urandom, 0));
        pending_reqs.push_back(make_req(REQ_INSERT, 1, 0));
        pending_reqs.push_back(make_req(REQ_PUSH_FRONT, 1, 0));
        pending_reqs.push_back(make_req(REQ_READ, 0, 63));
        pending_reqs.push_back(make_req(REQ_REMOVE, 0, 0));
        pending_reqs.push_back(make_req(REQ_INSERT, 2, 31));
        pending_reqs.push_back(make_req(REQ_READ, 0, 64));
        drain();
        for (k = 0; k < 3; k++) begin
            if (k == 1) begin
                send_idle = 56;
                recv_idle = 18;
            end else if (k == 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            queue_random(353);
            drain();
        end
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("[bounded_indexed_deque_core] OK");
        end else begin
            $display("[bounded_indexed_deque_core] ERROR");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/bidq_pkg.sv
hw/rtl/bidq_datapath.sv
hw/rtl/bidq_ctrl.sv
hw/rtl/bounded_indexed_deque_core.sv
test/tb.sv
